[design/sba_pkg.sv]
package sba_pkg;

    localparam int PIX_W      = 8;
    localparam int MAX_WIDTH  = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COL_W      = ADDR_W;
    localparam int ROW_W      = 16;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int LINE_W     = 2 * PIX_W;
    // |gradient| is at most 4 * 255, plus sign
    localparam int GRAD_W     = PIX_W + 4;
    localparam int MIN_DIM    = 3;
    localparam int PIX_MAX    = (1 << PIX_W) - 1;

    typedef logic [PIX_W-1:0]         t_pix;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [COL_W-1:0]         t_col;
    typedef logic [ROW_W-1:0]         t_row;
    typedef logic [FW_W-1:0]          t_fwidth;
    typedef logic [FH_W-1:0]          t_fheight;
    typedef logic [CFG_DATA_W-1:0]    t_cfg_data;
    typedef logic [LINE_W-1:0]        t_line;
    typedef logic signed [GRAD_W-1:0] t_grad;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // position of one pixel in the frame, as seen at acceptance
    typedef struct packed {
        t_addr addr;
        logic  emit;
        logic  last;
    } t_pos;

    // one pixel with its two upper neighbors, heading into the window
    typedef struct packed {
        t_pix px;
        t_pix up1;
        t_pix up2;
        logic emit;
        logic last;
    } t_kin;

    function automatic t_grad pix_ext(input t_pix p);
        return t_grad'({{(GRAD_W-PIX_W){1'b0}}, p});
    endfunction

    function automatic t_pix abs_sat(input t_grad v);
        t_grad a;
        a = (v < 0) ? -v : v;
        return (a > t_grad'(PIX_MAX)) ? t_pix'(PIX_MAX) : a[PIX_W-1:0];
    endfunction

endpackage

[design/sba_line_store.sv]
module sba_line_store (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  sba_pkg::t_addr i_rd_addr,
    output sba_pkg::t_line o_rd_data,
    input  logic          i_wr_en,
    input  sba_pkg::t_addr i_wr_addr,
    input  sba_pkg::t_line i_wr_data
);
    import sba_pkg::*;

    t_line r_mem [MAX_WIDTH];
    t_line r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/sba_counter.sv]
module sba_counter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  sba_pkg::t_fwidth  i_frame_width,
    input  sba_pkg::t_fheight i_frame_height,
    output sba_pkg::t_pos     o_pos
);
    import sba_pkg::*;

    t_col     r_col, n_col;
    t_row     r_row, n_row;
    t_fwidth  eff_w;
    t_fheight eff_h;
    t_col     last_col;
    t_row     last_row;
    logic     row_end;
    logic     frame_end;

    always_comb begin
        // clamp the frame width to what the line stores can hold, and both sizes to at least MIN_DIM
        if (i_frame_width < t_fwidth'(MIN_DIM)) begin
            eff_w = t_fwidth'(MIN_DIM);
        end else if (i_frame_width > t_fwidth'(MAX_WIDTH)) begin
            eff_w = t_fwidth'(MAX_WIDTH);
        end else begin
            eff_w = i_frame_width;
        end
        eff_h = (i_frame_height < t_fheight'(MIN_DIM)) ? t_fheight'(MIN_DIM)
                                                       : i_frame_height;
        last_col  = t_col'(eff_w - t_fwidth'(1));
        last_row  = t_row'(eff_h - t_fheight'(1));
        row_end   = (r_col >= last_col);
        frame_end = (r_row >= last_row);

        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + t_row'(1);
            end else begin
                n_col = r_col + t_col'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.addr = t_addr'(r_col);
    assign o_pos.emit = (r_col >= t_col'(2)) && (r_row >= t_row'(2));
    assign o_pos.last = row_end && frame_end;

endmodule

[design/sba_kernel.sv]
module sba_kernel (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_advance,
    input  sba_pkg::t_kin i_kin,
    input  logic         i_stall,
    output logic         o_valid,
    output sba_pkg::t_pix o_horiz_grad,
    output sba_pkg::t_pix o_vert_grad,
    output logic         o_frame_last
);
    import sba_pkg::*;

    // window[row][col]: row 0 oldest line, col 2 newest column
    t_pix  r_win [3][3];
    t_pix  n_win [3][3];
    t_grad gx;
    t_grad gy;
    logic  r_valid;
    t_pix  r_hg;
    t_pix  r_vg;
    logic  r_last;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = i_kin.up2;
        n_win[1][2] = i_kin.up1;
        n_win[2][2] = i_kin.px;

        gx = (pix_ext(n_win[0][2]) - pix_ext(n_win[0][0]))
           + ((pix_ext(n_win[1][2]) - pix_ext(n_win[1][0])) <<< 1)
           + (pix_ext(n_win[2][2]) - pix_ext(n_win[2][0]));
        gy = (pix_ext(n_win[0][0]) + (pix_ext(n_win[0][1]) <<< 1) + pix_ext(n_win[0][2]))
           - (pix_ext(n_win[2][0]) + (pix_ext(n_win[2][1]) <<< 1) + pix_ext(n_win[2][2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else begin
            if (i_advance) begin
                r_win <= n_win;
            end
            if (i_advance && i_kin.emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (i_advance && i_kin.emit) begin
            r_hg   <= abs_sat(gx);
            r_vg   <= abs_sat(gy);
            r_last <= i_kin.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_horiz_grad = r_hg;
    assign o_vert_grad  = r_vg;
    assign o_frame_last = r_last;

endmodule

[design/sobel_abs_derivatives_top.sv]
// Sobel 3x3 absolute-gradient engine, one 8-bit pixel per transaction, raster order.
// An accepted pixel waits in the acceptance stage, then shifts into the window as its result is registered.
// Throughput: 1 pixel per cycle unless the output stalls, set by the one-read, one-write line store.
// Reset (synchronous, active low): counters, window and valid flags clear, width 640, height 480.
// Line stores are not cleared; each entry is written one row before it is read.
module sobel_abs_derivatives_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // pixel input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  sba_pkg::t_pix      i_pixel,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output sba_pkg::t_pix      o_horiz_grad,
    output sba_pkg::t_pix      o_vert_grad,
    output logic               o_frame_last,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  sba_pkg::t_cfg_idx  i_cfg_index,
    input  sba_pkg::t_cfg_data i_cfg_data
);
    import sba_pkg::*;

    // configuration registers
    t_fwidth  r_frame_width;
    t_fheight r_frame_height;

    // acceptance stage: pixel and its frame position; line-store read in flight
    logic  r_a_valid;
    t_pix  r_a_px;
    t_pos  r_a_pos;

    logic  in_accept;
    logic  a_advance;
    t_pos  cur_pos;
    t_line rd_line;
    t_kin  kin;

    // The acceptance stage moves on whenever the result register is free
    // or being drained this cycle.
    assign a_advance = r_a_valid && (!o_valid || !i_stall);
    assign o_stall   = r_a_valid && !a_advance;
    assign in_accept = i_valid && !o_stall;

    // Configuration is always writable; the user must write it only while idle, the block does not enforce this.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= t_fwidth'(640);
            r_frame_height <= t_fheight'(480);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Column and row tracking; advance on every accepted transaction.
    sba_counter u_counter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (in_accept),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_pos          (cur_pos)
    );

    // Hold the accepted pixel until the window can take it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_advance) begin
            r_a_valid <= 1'b0;
        end
        if (in_accept) begin
            r_a_px  <= i_pixel;
            r_a_pos <= cur_pos;
        end
    end

    // Both line stores share one memory: upper byte is the previous row,
    // lower byte the row before it. Read at acceptance, write back the
    // shifted pair when the pixel enters the window. Consecutive pixels
    // never share a column, so the write never collides with the next read.
    sba_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (cur_pos.addr),
        .o_rd_data (rd_line),
        .i_wr_en   (a_advance),
        .i_wr_addr (r_a_pos.addr),
        .i_wr_data ({r_a_px, rd_line[LINE_W-1:PIX_W]})
    );

    assign kin.px   = r_a_px;
    assign kin.up1  = rd_line[LINE_W-1:PIX_W];
    assign kin.up2  = rd_line[PIX_W-1:0];
    assign kin.emit = r_a_pos.emit;
    assign kin.last = r_a_pos.last;

    // Shift the window, compute both gradients, load the result register.
    sba_kernel u_kernel (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (a_advance),
        .i_kin        (kin),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_horiz_grad (o_horiz_grad),
        .o_vert_grad  (o_vert_grad),
        .o_frame_last (o_frame_last)
    );

endmodule
